// ===== sv/ddp_pkg.sv =====
// Package for the pixel packet framer: sizes, header byte values,
// byte positions within one queued pixel, and the front-to-back queue entry.
// No dependencies.
package ddp_pkg;

    // Packet and frame sizing
    localparam int PIXELS_PER_PACKET = 480;
    localparam int FRM_W             = 20;                        // frame pixel counts
    localparam int PPC_W             = $clog2(PIXELS_PER_PACKET + 1);
    localparam int OFF_W             = 32;                        // header byte offset
    localparam int LEN_W             = 16;                        // header data length
    localparam int COLOR_W           = 8;

    // Queue between classifier and byte sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Header byte values
    localparam logic [7:0] FLAGS_PLAIN = 8'h40;
    localparam logic [7:0] FLAGS_PUSH  = 8'h41;
    localparam logic [7:0] SEQ_VALUE   = 8'h00;
    localparam logic [7:0] TYPE_VALUE  = 8'h00;
    localparam logic [7:0] ID_VALUE    = 8'h01;

    // Byte positions: ten header bytes, then the three colour bytes
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_FLAGS = 4'd0;
    localparam logic [POS_W-1:0] POS_SEQ   = 4'd1;
    localparam logic [POS_W-1:0] POS_TYPE  = 4'd2;
    localparam logic [POS_W-1:0] POS_ID    = 4'd3;
    localparam logic [POS_W-1:0] POS_OFF3  = 4'd4;
    localparam logic [POS_W-1:0] POS_OFF2  = 4'd5;
    localparam logic [POS_W-1:0] POS_OFF1  = 4'd6;
    localparam logic [POS_W-1:0] POS_OFF0  = 4'd7;
    localparam logic [POS_W-1:0] POS_LEN1  = 4'd8;
    localparam logic [POS_W-1:0] POS_LEN0  = 4'd9;
    localparam logic [POS_W-1:0] POS_RED   = 4'd10;
    localparam logic [POS_W-1:0] POS_GREEN = 4'd11;
    localparam logic [POS_W-1:0] POS_BLUE  = 4'd12;

    // One classified pixel
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               hdr;      // pixel opens a packet
        logic               push;     // packet is the frame's last
        logic [OFF_W-1:0]   offset;
        logic [LEN_W-1:0]   len;
        logic               pkt_end;
        logic               frm_end;
    } t_entry;

endpackage

// ===== sv/ddp_front.sv =====
// Front end of the framer: takes pixels, tracks frame/packet position and
// pushes one classified entry per pixel into the queue. Depends on ddp_pkg.
module ddp_front import ddp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [FRM_W-1:0] i_cfg_wr_data,
    input  logic             i_valid,
    input  logic [23:0]      i_data,
    output logic             o_ready,
    input  logic             i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [FRM_W-1:0] r_frame_pixels;
    logic [FRM_W-1:0] r_left,   n_left;
    logic [PPC_W-1:0] r_ppc,    n_ppc;
    logic [OFF_W-1:0] r_offset, n_offset;

    logic             start_frame;
    logic [FRM_W-1:0] left_cur;
    logic [PPC_W-1:0] ppc_cur, ppc_inc, pkt_pixels;
    logic [OFF_W-1:0] off_cur;
    logic             push_pkt, frm_end, pkt_end;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    // Frame start reloads the pixel budget and clears the packet position
    always_comb begin
        start_frame = (r_left == '0);
        left_cur    = start_frame ? ((r_frame_pixels == '0) ? FRM_W'(1) : r_frame_pixels)
                                  : r_left;
        ppc_cur     = start_frame ? '0 : r_ppc;
        off_cur     = start_frame ? '0 : r_offset;
        push_pkt    = (left_cur <= FRM_W'(PIXELS_PER_PACKET));
        pkt_pixels  = push_pkt ? PPC_W'(left_cur) : PPC_W'(PIXELS_PER_PACKET);
        ppc_inc     = ppc_cur + PPC_W'(1);
        n_left      = left_cur - FRM_W'(1);
        frm_end     = (n_left == '0);
        pkt_end     = frm_end || (ppc_inc >= PPC_W'(PIXELS_PER_PACKET));
        n_ppc       = pkt_end ? '0 : ppc_inc;
        if (frm_end) begin
            n_offset = '0;
        end else if (pkt_end) begin
            n_offset = off_cur + OFF_W'(ppc_inc) + (OFF_W'(ppc_inc) << 1);
        end else begin
            n_offset = off_cur;
        end
    end

    // Entry contents
    always_comb begin
        o_entry.red     = i_data[7:0];
        o_entry.green   = i_data[15:8];
        o_entry.blue    = i_data[23:16];
        o_entry.hdr     = (ppc_cur == '0);
        o_entry.push    = push_pkt;
        o_entry.offset  = off_cur;
        o_entry.len     = LEN_W'(pkt_pixels) + (LEN_W'(pkt_pixels) << 1);
        o_entry.pkt_end = pkt_end;
        o_entry.frm_end = frm_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FRM_W'(PIXELS_PER_PACKET);
            r_left         <= '0;
            r_ppc          <= '0;
            r_offset       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_pixels <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_left   <= n_left;
                r_ppc    <= n_ppc;
                r_offset <= n_offset;
            end
        end
    end

    // A packet never runs past its pixel limit
    a_ppc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ppc < PPC_W'(PIXELS_PER_PACKET))
        else $error("packet pixel count out of range");

    // Closing a frame leaves the block waiting for a new frame start
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && frm_end) |=> (r_left == '0 && r_offset == '0 && r_ppc == '0))
        else $error("frame end did not clear position");

endmodule

// ===== sv/ddp_queue.sv =====
// Short queue of classified pixel entries between front and back.
// Depends on ddp_pkg.
module ddp_queue import ddp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule

// ===== sv/ddp_back.sv =====
// Back end of the framer: walks the header and colour bytes of the queue
// head, one byte per cycle while the output is ready, into the output register. Depends on ddp_pkg.
module ddp_back import ddp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_entry      i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte,
    output logic [2:0]  o_user,
    output logic        o_last
);

    logic             r_active;
    logic [POS_W-1:0] r_pos;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic [2:0]       r_user;
    logic             r_last;

    logic             emit;
    logic [POS_W-1:0] cur_pos;
    logic [7:0]       n_byte;
    logic             is_blue;

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_user  = r_user;
    assign o_last  = r_last;

    // A new entry starts at its first header byte or straight at red
    assign cur_pos = r_active ? r_pos : (i_head.hdr ? POS_FLAGS : POS_RED);
    assign emit    = i_q_valid && (!r_valid || i_ready);
    assign is_blue = (cur_pos == POS_BLUE);
    assign o_pop   = emit && is_blue;

    // Byte select
    always_comb begin
        unique case (cur_pos)
            POS_FLAGS: n_byte = i_head.push ? FLAGS_PUSH : FLAGS_PLAIN;
            POS_SEQ:   n_byte = SEQ_VALUE;
            POS_TYPE:  n_byte = TYPE_VALUE;
            POS_ID:    n_byte = ID_VALUE;
            POS_OFF3:  n_byte = i_head.offset[31:24];
            POS_OFF2:  n_byte = i_head.offset[23:16];
            POS_OFF1:  n_byte = i_head.offset[15:8];
            POS_OFF0:  n_byte = i_head.offset[7:0];
            POS_LEN1:  n_byte = i_head.len[15:8];
            POS_LEN0:  n_byte = i_head.len[7:0];
            POS_RED:   n_byte = i_head.red;
            POS_GREEN: n_byte = i_head.green;
            POS_BLUE:  n_byte = i_head.blue;
            default:   n_byte = '0;
        endcase
    end

    // Sequencer position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (emit) begin
            r_active <= !is_blue;
            r_pos    <= cur_pos + POS_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_user <= {is_blue && i_head.frm_end, is_blue && i_head.pkt_end,
                       cur_pos == POS_FLAGS};
            r_last <= is_blue;
        end
    end

    // Mid-entry the head must still be present
    a_active_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> i_q_valid)
        else $error("sequencer active without queue head");

    // Position never walks past the blue byte
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pos <= POS_BLUE))
        else $error("byte position out of range");

endmodule

// ===== sv/ddp_pixel_packet_framer_top.sv =====
// Top level of the pixel packet framer: front classifier, entry queue and
// byte sequencer. Depends on ddp_pkg, ddp_front, ddp_queue, ddp_back.
//
//   channel   direction  payload
//   s_axis    in         tdata = red[7:0], green[15:8], blue[23:16]
//   m_axis    out        tdata = out_byte; tuser = packet_start, packet_end,
//                        frame_end; tlast = last_of_run
//   cfg       in         write enable + frame_pixels (20 bits)
//
// Each pixel leaves as 3 output bytes, or 13 when it opens a packet; the
// byte-wide output register moves one byte per cycle while the output is ready.
// A pixel's first byte is registered in the queue, then in the output register.
// Reset is synchronous, active low; frame_pixels returns to 480.
// A 4-entry queue lets pixel intake run ahead while the output stalls.
module ddp_pixel_packet_framer_top import ddp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [FRM_W-1:0] i_cfg_wr_data,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [23:0]      i_s_axis_tdata,   // red, green, blue
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // out_byte
    output logic [2:0]       o_m_axis_tuser,   // packet_start, packet_end, frame_end
    output logic             o_m_axis_tlast    // last_of_run
);

    logic   q_full, q_push, q_pop, q_valid;
    t_entry q_in, q_head;

    ddp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .i_data        (i_s_axis_tdata),
        .o_ready       (o_s_axis_tready),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_entry       (q_in)
    );

    ddp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    ddp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (o_m_axis_tdata),
        .o_user    (o_m_axis_tuser),
        .o_last    (o_m_axis_tlast)
    );

    // Frame end only on a packet's closing byte
    a_frame_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[2]) |-> (o_m_axis_tuser[1] && o_m_axis_tlast))
        else $error("frame end without packet end");

    // A packet start is a header byte, never the pixel's last byte
    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> !o_m_axis_tlast)
        else $error("packet start on last byte");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for ddp_pixel_packet_framer_top: pixel transfers in,
// packet byte transfers out, checked against an in-bench packet predictor.
// Depends on ddp_pkg and the framer RTL.
module tb;
    import ddp_pkg::*;

    // Fields of one packet opening as predicted for a pixel
    typedef struct packed {
        logic               hdr;
        logic [7:0]         flags;
        logic [OFF_W-1:0]   off;
        logic [LEN_W-1:0]   len;
        logic               pend;
        logic               fend;
    } t_pkt_fields;

    // One output byte with its side flags
    typedef struct packed {
        logic [7:0] data;
        logic       pstart;
        logic       pend;
        logic       fend;
        logic       last;
    } t_out_beat;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_CFG, ROW_FLUSH} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [23:0] value;    // pixel or frame length
        logic        typed;    // use the typed-in header below
        t_pkt_fields want;
    } t_stim_row;

    localparam int RAND_PIXELS = 280;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [FRM_W-1:0] i_cfg_wr_data = '0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [23:0]      i_s_axis_tdata = '0;   // red, green, blue
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [7:0]       o_m_axis_tdata;        // out_byte
    logic [2:0]       o_m_axis_tuser;        // packet_start, packet_end, frame_end
    logic             o_m_axis_tlast;        // last_of_run

    ddp_pixel_packet_framer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Predictor state
    logic [FRM_W-1:0] frame_len_reg;
    logic [FRM_W-1:0] pix_left;
    logic [PPC_W-1:0] pix_in_pkt;
    logic [OFF_W-1:0] pkt_offset;

    t_out_beat pending_bytes[$];
    t_stim_row dir_rows[$];
    int        mismatch_count = 0;
    logic      calm = 1'b0;       // no idling on either side
    int        rdy_hold = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [23:0] rand_px();
        case ($urandom_range(0, 9))
            0: rand_px = 24'h000000;
            1: rand_px = 24'hFFFFFF;
            default: rand_px = 24'($urandom());
        endcase
    endfunction

    // Mostly short frames, some around one packet size
    function automatic logic [FRM_W-1:0] rand_frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return FRM_W'($urandom_range(0, 24));
        if (r < 90) return FRM_W'($urandom_range(470, 490));
        return FRM_W'($urandom_range(25, 200));
    endfunction

    // Advance the framer state by one pixel; returns what its bytes carry
    function automatic t_pkt_fields take_pixel();
        t_pkt_fields f;
        logic [FRM_W-1:0] n;
        logic push;
        f = '0;
        if (pix_left == 0) begin
            pix_left   = (frame_len_reg == 0) ? FRM_W'(1) : frame_len_reg;
            pix_in_pkt = '0;
            pkt_offset = '0;
        end
        f.hdr = (pix_in_pkt == 0);
        if (f.hdr) begin
            n    = pix_left;
            push = (n <= PIXELS_PER_PACKET);
            if (!push) n = FRM_W'(PIXELS_PER_PACKET);
            f.flags = push ? FLAGS_PUSH : FLAGS_PLAIN;
            f.off   = pkt_offset;
            f.len   = LEN_W'(n * 3);
        end
        pix_in_pkt = pix_in_pkt + 1'b1;
        pix_left   = pix_left - 1'b1;
        f.fend = (pix_left == 0);
        f.pend = f.fend || (pix_in_pkt >= PIXELS_PER_PACKET);
        if (f.pend) begin
            pkt_offset = pkt_offset + OFF_W'(pix_in_pkt * 3);
            pix_in_pkt = '0;
        end
        if (f.fend) pkt_offset = '0;
        return f;
    endfunction

    function automatic void push_beat(logic [7:0] d, logic ps, logic pe, logic fe, logic l);
        t_out_beat b;
        b.data = d; b.pstart = ps; b.pend = pe; b.fend = fe; b.last = l;
        pending_bytes.insert(pending_bytes.size(), b);
    endfunction

    // Header (when the pixel opens a packet), then red, green, blue
    function automatic void queue_pixel_bytes(t_pkt_fields f, logic [23:0] px);
        if (f.hdr) begin
            push_beat(f.flags, 1'b1, 1'b0, 1'b0, 1'b0);
            push_beat(SEQ_VALUE, 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(TYPE_VALUE, 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(ID_VALUE, 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(f.off[31:24], 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(f.off[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(f.off[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(f.off[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(f.len[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
            push_beat(f.len[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
        end
        push_beat(px[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
        push_beat(px[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
        push_beat(px[23:16], 1'b0, f.pend, f.fend, 1'b1);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // Stimulus table builders
    function automatic t_stim_row pix_row(logic [23:0] px);
        t_stim_row r;
        r = '0; r.kind = ROW_PIXEL; r.value = px;
        return r;
    endfunction

    function automatic t_stim_row pix_typed(logic [23:0] px, logic hdr, logic [7:0] flags,
                                            logic [OFF_W-1:0] off, logic [LEN_W-1:0] len,
                                            logic pend, logic fend);
        t_stim_row r;
        r = pix_row(px);
        r.typed = 1'b1;
        r.want.hdr = hdr; r.want.flags = flags; r.want.off = off; r.want.len = len;
        r.want.pend = pend; r.want.fend = fend;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [FRM_W-1:0] v);
        t_stim_row r;
        r = '0; r.kind = ROW_CFG; r.value = 24'(v);
        return r;
    endfunction

    function automatic t_stim_row flush_row();
        t_stim_row r;
        r = '0; r.kind = ROW_FLUSH;
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_stim_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // One pixel transfer; expectations are queued at the accepting edge
    task automatic send_pixel(logic [23:0] px, logic typed, t_pkt_fields want);
        int gap;
        t_pkt_fields f;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
        f = take_pixel();
        queue_pixel_bytes(typed ? want : f, px);
    endtask

    // Stop sending and wait until every queued byte has come out
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_frame_len(logic [FRM_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        frame_len_reg = v;
    endtask

    // Output ready: random stretches of ready and stall
    always @(posedge i_clk) begin
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(0, 3) != 0);
            rdy_hold        <= pick_gap();
        end
    end

    // Output checker
    always @(posedge i_clk) begin
        t_out_beat w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("transfer with nothing outstanding", o_m_axis_tdata, 0);
            end else begin
                w = pending_bytes.pop_front();
                if (o_m_axis_tdata !== w.data)
                    report_mismatch("out_byte", o_m_axis_tdata, w.data);
                if (o_m_axis_tuser[0] !== w.pstart)
                    report_mismatch("packet_start", o_m_axis_tuser[0], w.pstart);
                if (o_m_axis_tuser[1] !== w.pend)
                    report_mismatch("packet_end", o_m_axis_tuser[1], w.pend);
                if (o_m_axis_tuser[2] !== w.fend)
                    report_mismatch("frame_end", o_m_axis_tuser[2], w.fend);
                if (o_m_axis_tlast !== w.last)
                    report_mismatch("last_of_run", o_m_axis_tlast, w.last);
            end
        end
    end

    initial begin
        int rand_sent;
        int n;
        rand_sent = 0;
        frame_len_reg = FRM_W'(480);
        pix_left      = '0;
        pix_in_pkt    = '0;
        pkt_offset    = '0;

        // Directed table
        add_row(pix_typed(24'hFF00FF, 1, FLAGS_PUSH, 0, 16'd1440, 0, 0)); // reset length
        add_row(cfg_row(0));        // mid-frame write waits for frame end
        add_row(pix_row(24'h00FF00));
        add_row(flush_row());       // full 480 frame: full length in header
        add_row(pix_typed(24'h000000, 1, FLAGS_PUSH, 0, 16'd3, 1, 1)); // zero length
        add_row(pix_typed(24'hFFFFFF, 1, FLAGS_PUSH, 0, 16'd3, 1, 1));
        add_row(cfg_row(1));
        add_row(pix_typed(24'hC3A55A, 1, FLAGS_PUSH, 0, 16'd3, 1, 1));
        add_row(cfg_row(2));
        add_row(pix_typed(24'h563412, 1, FLAGS_PUSH, 0, 16'd6, 0, 0));
        add_row(pix_typed(24'h214365, 0, 8'h00, 0, 16'd0, 1, 1));
        add_row(cfg_row(481));      // one full packet, then one pixel
        add_row(pix_typed(24'h0F0F0F, 1, FLAGS_PLAIN, 0, 16'd1440, 0, 0));
        add_row(flush_row());
        add_row(cfg_row(3));
        add_row(pix_row(24'hF0F0F0));
        add_row(pix_row(24'h0000FF));
        add_row(pix_row(24'hFF0000));
        add_row(pix_row(24'h808080));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    drain();
                    write_frame_len(dir_rows[i].value[FRM_W-1:0]);
                end
                ROW_FLUSH: begin
                    while (pix_left != 0) send_pixel(rand_px(), 1'b0, '0);
                end
                default: begin
                    send_pixel(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
                end
            endcase
        end

        // Random phases, each opened by a length write on an idle block
        while (rand_sent < RAND_PIXELS) begin
            drain();
            write_frame_len(rand_frame_len());
            calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(5, 40);
            repeat (n) begin
                send_pixel(rand_px(), 1'b0, '0);
                rand_sent++;
            end
        end
        calm = 1'b0;

        // Longest frame last: it never completes within the run
        while (pix_left != 0) send_pixel(rand_px(), 1'b0, '0);
        drain();
        write_frame_len({FRM_W{1'b1}});
        repeat (6) send_pixel(rand_px(), 1'b0, '0);

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bytes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ddp_pkg.sv
sv/ddp_front.sv
sv/ddp_queue.sv
sv/ddp_back.sv
sv/ddp_pixel_packet_framer_top.sv
tb/sv/tb.sv
